// ----- hw/rtl/til_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// til_pkg: shared types and constants of the trie insert/lookup core
// Request and result layouts, the classified queue entry and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package til_pkg;

  localparam int SYM_W   = 8;
  localparam int LIMIT_W = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } til_in_t;

  typedef struct packed {
    logic present;
    logic no_room;
  } til_out_t;

  // A request after classification by the front end.
  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             sym_ok;
  } til_req_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/til_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// til_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module til_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/til_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// til_front: request intake and classification
// Checks each symbol against the row width and holds classified requests in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module til_front #(
  parameter int SYMBOLS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  til_pkg::til_in_t  in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output til_pkg::til_req_t q_req
);
  import til_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CNTW   = $clog2(QDEPTH + 1);
  localparam int SLW    = SYM_W + 1;
  localparam logic [SLW-1:0] SYM_LIMIT = SLW'(SYMBOLS);

  til_req_t        ent_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  til_req_t        req_in;
  logic            push, pop;

  always_comb begin
    req_in.mode   = in_item.mode;
    req_in.symbol = in_item.symbol;
    req_in.last   = in_item.last;
    req_in.sym_ok = {1'b0, in_item.symbol} < SYM_LIMIT;
  end

  assign in_ready = (count_r != CNTW'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_req    = ent_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= req_in;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/til_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// til_back: trie walk sequencer
// Clears the transition table after reset, then walks one request at a time:
// a fetch state reads the table entry, an execute state decides the step,
// writes edges and end marks and, for a final byte, loads the result register.
// ----------------------------------------------------------------------------
module til_back #(
  parameter int NODES   = 1024,
  parameter int SYMBOLS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  til_pkg::til_req_t           q_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output til_pkg::til_out_t           out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [til_pkg::LIMIT_W-1:0] cfg_data
);
  import til_pkg::*;

  localparam int NW    = $clog2(NODES);
  localparam int FW    = NW + 1;
  localparam int SW    = $clog2(SYMBOLS);
  localparam int DEPTH = NODES * SYMBOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = NW + 1;
  localparam int CW    = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam logic [AW-1:0] SYM_CNT   = AW'(SYMBOLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] TOP_NODE  = CW'(NODES - 1);

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [NW-1:0]      cur_node_r, cur_node_nxt;
  logic [FW-1:0]      free_node_r, free_node_nxt;
  logic               failed_r, failed_nxt;
  logic               made_new_r, made_new_nxt;
  til_req_t           req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  til_out_t           out_item_r, out_item_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  logic               ram_wr_en, ram_rd_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [EW-1:0]      ram_wr_data, ram_rd_data;

  logic [SW-1:0]      sym_idx;
  logic [AW-1:0]      fetch_slot;
  logic [NW-1:0]      edge_node;
  logic               edge_mark, hit;
  logic [CW-1:0]      lim_in_force;
  logic               room, can_finish, take, commit;
  logic               step_fail, step_new, step_alloc, step_mark;
  logic [NW-1:0]      step_node;
  logic               exec_wr;
  logic [EW-1:0]      exec_wdata;
  til_out_t           res;

  // Each table entry holds the child node and, in its top bit, the end mark
  // of that child. Every node but the root has exactly one incoming edge and
  // the root never ends a word, so the mark can live on the edge.
  til_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (fetch_slot),
    .rd_data (ram_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sym_idx      = q_req.sym_ok ? q_req.symbol[SW-1:0] : '0;
    fetch_slot   = AW'(cur_node_r) * SYM_CNT + AW'(sym_idx);
    edge_node    = ram_rd_data[NW-1:0];
    edge_mark    = ram_rd_data[NW];
    hit          = (edge_node != '0);
    lim_in_force = (CW'(limit_r) < TOP_NODE) ? CW'(limit_r) : TOP_NODE;
    room         = (CW'(free_node_r) <= lim_in_force);
    can_finish   = !req_r.last || !out_valid_r || out_ready;
  end

  // One step of the walk for the request held in req_r.
  always_comb begin
    step_fail  = failed_r;
    step_node  = cur_node_r;
    step_new   = made_new_r;
    step_alloc = 1'b0;
    step_mark  = 1'b0;
    if (!failed_r) begin
      if (!req_r.sym_ok) begin
        step_fail = 1'b1;
      end else if (hit) begin
        step_node = edge_node;
        step_mark = edge_mark;
      end else if (!req_r.mode) begin
        step_fail = 1'b1;
      end else if (room) begin
        step_node  = free_node_r[NW-1:0];
        step_alloc = 1'b1;
        step_new   = 1'b1;
      end else begin
        step_fail = 1'b1;
      end
    end

    if (req_r.mode) begin
      res.no_room = step_fail;
      res.present = !step_fail && !step_new && step_mark;
    end else begin
      res.no_room = 1'b0;
      res.present = !step_fail && step_mark;
    end

    exec_wr    = !failed_r && req_r.sym_ok && req_r.mode && (hit ? req_r.last : room);
    exec_wdata = hit ? {1'b1, edge_node} : {req_r.last, free_node_r[NW-1:0]};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = BK_FETCH;
        end
      end
      BK_FETCH: begin
        if (q_valid) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (can_finish) begin
          state_nxt = BK_FETCH;
        end
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_ready     = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot_r;
    ram_wr_data = exec_wdata;
    take        = 1'b0;
    commit      = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr_r;
        ram_wr_data = '0;
      end
      BK_FETCH: begin
        q_ready   = 1'b1;
        ram_rd_en = q_valid;
        take      = q_valid;
      end
      BK_EXEC: begin
        commit    = can_finish;
        ram_wr_en = can_finish && exec_wr;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  // Walk state, free counter and result register
  always_comb begin
    clr_addr_nxt  = (state_r == BK_CLEAR) ? clr_addr_r + AW'(1) : clr_addr_r;
    slot_nxt      = take ? fetch_slot : slot_r;
    req_nxt       = take ? q_req : req_r;
    cur_node_nxt  = cur_node_r;
    failed_nxt    = failed_r;
    made_new_nxt  = made_new_r;
    free_node_nxt = free_node_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    limit_nxt     = cfg_valid ? cfg_data : limit_r;
    if (commit) begin
      free_node_nxt = free_node_r + FW'(step_alloc);
      if (req_r.last) begin
        cur_node_nxt  = '0;
        failed_nxt    = 1'b0;
        made_new_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
        out_item_nxt  = res;
      end else begin
        cur_node_nxt = step_node;
        failed_nxt   = step_fail;
        made_new_nxt = step_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      cur_node_r  <= '0;
      free_node_r <= FW'(1);
      failed_r    <= 1'b0;
      made_new_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_node_r  <= cur_node_nxt;
      free_node_r <= free_node_nxt;
      failed_r    <= failed_nxt;
      made_new_r  <= made_new_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    req_r      <= req_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/trie_insert_lookup_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trie_insert_lookup_core: dictionary trie with byte-wise insert and lookup
// Words arrive one byte per request; the final byte returns one result.
// ----------------------------------------------------------------------------
// After reset the core sweeps the whole transition table to zero, one entry
// per cycle; the input queue fills during the sweep but no request is
// processed until it ends, while node_limit writes are taken at any time.
// Thereafter each byte passes through a fetch state, which reads the table
// entry for the current node and symbol from the registered-read RAM, and
// an execute state, which decides the step and writes back any new edge or
// end mark. A two-entry queue in front and a result register behind let the
// input and result sides stall independently.
module trie_insert_lookup_core #(
  parameter int NODES   = 1024,
  parameter int SYMBOLS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  til_pkg::til_in_t            in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output til_pkg::til_out_t           out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [til_pkg::LIMIT_W-1:0] cfg_data
);
  import til_pkg::*;

  logic     q_valid;
  logic     q_ready;
  til_req_t q_req;

  til_front #(
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  til_back #(
    .NODES   (NODES),
    .SYMBOLS (SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/til_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// til_checker: port-level checks for the trie insert/lookup core
// Watches the result and configuration ports and is bound to the top level.
// ----------------------------------------------------------------------------
module til_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input til_pkg::til_out_t out_item,
  input logic              cfg_ready
);

  // A result held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // A word is either found or failed for lack of room, never both.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.present && out_item.no_room))
    else $error("present and no_room both set");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration write refused");

endmodule

bind trie_insert_lookup_core til_checker u_til_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the trie insert/lookup core
// Feeds words byte by byte over the request channel, keeps a bit-accurate
// shadow of the transition table, end marks and free-node counter, and
// checks every returned result in order. The node limit is moved between
// phases, from one node to the full table, so that inserts run out of room.
// ----------------------------------------------------------------------------
module tb_top;
  import til_pkg::*;

  localparam int NODES        = 1024;
  localparam int SYMBOLS      = 256;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  // The table sweep after reset is by far the longest quiet stretch.
  localparam int QUIET_LIMIT  = 4 * NODES * SYMBOLS;
  localparam bit MODE_LOOKUP  = 1'b0;
  localparam bit MODE_INSERT  = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  til_in_t              in_item;
  logic                 out_valid;
  logic                 out_ready;
  til_out_t             out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;

  trie_insert_lookup_core #(
    .NODES   (NODES),
    .SYMBOLS (SYMBOLS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow trie state.
  bit [9:0]     trie_edge [NODES*SYMBOLS];
  bit           word_end [NODES];
  int unsigned  free_cnt = 1;
  bit [9:0]     walk_node;
  bit           walk_broken;
  bit           walk_grew;
  bit [9:0]     node_limit_q = LIMIT_RESET;

  til_in_t      byte_q [$];
  til_out_t     result_exp_q [$];
  int           bytes_queued;
  int           bytes_taken;
  int           results_seen;
  int           present_seen;
  int           no_room_seen;
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_requests;
  int           holds_served;
  int           quiet_cycles;

  // Advances the shadow walk by one byte; returns a result on the final byte.
  function automatic void trie_step(input til_in_t req, output bit done,
                                    output til_out_t res);
    int unsigned slot;
    int unsigned top;
    bit [9:0]    nxt;
    bit          is_ins;
    is_ins = (req.mode == MODE_INSERT);
    top    = (node_limit_q < NODES - 1) ? node_limit_q : NODES - 1;
    done   = req.last;
    res    = '0;
    if (!walk_broken) begin
      if (req.symbol >= SYMBOLS) begin
        walk_broken = 1'b1;
      end else begin
        slot = walk_node * SYMBOLS + req.symbol;
        nxt  = trie_edge[slot];
        if (nxt != 0) begin
          walk_node = nxt;
        end else if (!is_ins) begin
          walk_broken = 1'b1;
        end else if (free_cnt <= top) begin
          trie_edge[slot] = free_cnt[9:0];
          walk_node       = free_cnt[9:0];
          free_cnt++;
          walk_grew = 1'b1;
        end else begin
          walk_broken = 1'b1;
        end
      end
    end
    if (req.last) begin
      if (is_ins) begin
        if (walk_broken) begin
          res.no_room = 1'b1;
        end else begin
          res.present         = !walk_grew && word_end[walk_node];
          word_end[walk_node] = 1'b1;
        end
      end else if (!walk_broken) begin
        res.present = word_end[walk_node];
      end
      walk_node   = '0;
      walk_broken = 1'b0;
      walk_grew   = 1'b0;
    end
  endfunction

  // Request driver: predicts at acceptance, then offers the next queued byte.
  always @(posedge clk) begin : drive_bytes
    til_in_t  nxt_item;
    bit       nxt_valid;
    bit       has_res;
    til_out_t res;
    nxt_item  = in_item;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        trie_step(in_item, has_res, res);
        if (has_res) begin
          result_exp_q.push_back(res);
        end
        bytes_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_item  = byte_q.pop_front();
        nxt_valid = 1'b1;
      end
    end else begin
      nxt_valid = 1'b0;
    end
    in_item  <= nxt_item;
    in_valid <= nxt_valid;
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : check_results
    til_out_t want;
    bit       nxt_ready;
    int       hold_left;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_item.present) present_seen++;
      if (out_item.no_room) no_room_seen++;
      if (result_exp_q.size() == 0) begin
        $display("%0t: result with none expected: present=%0b no_room=%0b",
                 $time, out_item.present, out_item.no_room);
        errors++;
      end else begin
        want = result_exp_q.pop_front();
        if (out_item.present !== want.present || out_item.no_room !== want.no_room) begin
          $display({"%0t: result mismatch, expected present=%0b no_room=%0b,",
                    " got present=%0b no_room=%0b"},
                   $time, want.present, want.no_room, out_item.present, out_item.no_room);
          errors++;
        end
      end
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic add_byte(input bit mode, input bit [7:0] sym, input bit last);
    til_in_t req;
    req.mode   = mode;
    req.symbol = sym;
    req.last   = last;
    byte_q.push_back(req);
    bytes_queued++;
  endtask

  // Words are mostly short, with most bytes drawn from four values, so that they
  // share prefixes and lookups often hit; a few bytes flip mode mid-word.
  task automatic add_random_word();
    int       len;
    bit       word_mode;
    bit       m;
    bit [7:0] s;
    len       = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    word_mode = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      m = ($urandom_range(19) == 0) ? ~word_mode : word_mode;
      if ($urandom_range(3) == 0) begin
        s = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0: s = 8'h00;
          1: s = 8'hFF;
          2: s = 8'h55;
          default: s = 8'hAA;
        endcase
      end
      add_byte(m, s, i == len - 1);
    end
  endtask

  task automatic add_random_bytes(input int count);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      add_random_word();
    end
  endtask

  // A final byte leaves no trace once its result is back, but trailing
  // non-final bytes may still be in flight, hence the extra cycles.
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || result_exp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_limit(input bit [9:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    node_limit_q  = value;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    send_idle_pct = 23;
    recv_idle_pct = 84;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A single allocatable node: the second new word must run out of room.
    write_node_limit(10'd1);
    add_byte(MODE_INSERT, 8'h00, 1'b1);
    add_byte(MODE_LOOKUP, 8'h00, 1'b1);
    add_byte(MODE_INSERT, 8'h00, 1'b1);
    add_byte(MODE_INSERT, 8'hFF, 1'b1);
    add_byte(MODE_LOOKUP, 8'hFF, 1'b1);
    add_byte(MODE_LOOKUP, 8'h00, 1'b0);
    add_byte(MODE_LOOKUP, 8'hFF, 1'b1);
    wait_idle();

    write_node_limit(10'd1023);
    add_byte(MODE_INSERT, 8'hFF, 1'b0);
    add_byte(MODE_INSERT, 8'h55, 1'b1);
    add_byte(MODE_LOOKUP, 8'hFF, 1'b1);
    add_byte(MODE_INSERT, 8'hFF, 1'b1);
    // Mixed modes: a lookup that breaks the path, and an insert after a
    // broken lookup step.
    add_byte(MODE_INSERT, 8'hAA, 1'b0);
    add_byte(MODE_LOOKUP, 8'h01, 1'b1);
    add_byte(MODE_LOOKUP, 8'h13, 1'b0);
    add_byte(MODE_INSERT, 8'h7E, 1'b1);
    wait_idle();

    // Lowering the limit leaves existing nodes reachable.
    write_node_limit(10'd1);
    add_byte(MODE_LOOKUP, 8'hFF, 1'b0);
    add_byte(MODE_LOOKUP, 8'h55, 1'b1);
    add_byte(MODE_INSERT, 8'hFF, 1'b0);
    add_byte(MODE_INSERT, 8'h55, 1'b1);
    add_byte(MODE_INSERT, 8'h80, 1'b1);
    wait_idle();

    write_node_limit(10'd1023);
    add_random_bytes(295);
    wait_idle();

    // A little headroom above the nodes in use, so that inserts exhaust it.
    send_idle_pct = 84;
    recv_idle_pct = 23;
    write_node_limit((free_cnt + 25 > 1023) ? 10'd1023 : 10'(free_cnt + 25));
    add_random_bytes(295);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_node_limit(10'd1023);
    add_random_bytes(295);
    hold_requests++;
    wait_idle();

    $display("Ran %0d bytes giving %0d results: %0d present, %0d out of room.",
             bytes_taken, results_seen, present_seen, no_room_seen);
    $display("Node limits 1, 1023 and a near-full setting; %0d nodes allocated.",
             free_cnt - 1);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
